### hdl/aclru_pkg.sv
// Shared constants, codes and types of the associative LRU cache.
package aclru_pkg;

   // Field widths fixed by the item format.
   localparam int KEY_W   = 64;
   localparam int STAMP_W = 64;
   localparam int COUNT_W = 32;
   localparam int SLOT_W  = 4;
   localparam int OP_W    = 2;

   // Defaults for the top-level parameters.
   localparam int ENTRIES_DEFAULT       = 16;
   localparam int PAYLOAD_WIDTH_DEFAULT = 64;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Operation codes carried in the request.
   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP     = 2'd0,
      OP_INSERT     = 2'd1,
      OP_INVALIDATE = 2'd2
   } op_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_COMMIT
   } state_type;

endpackage

### hdl/aclru_req_if.sv
// Request channel: operation, key and payload with valid/ready handshake.
interface aclru_req_if #(
   parameter int PAYLOAD_WIDTH = aclru_pkg::PAYLOAD_WIDTH_DEFAULT
);
   logic                           valid;
   logic                           ready;
   logic [aclru_pkg::OP_W-1:0]     operation;
   logic [aclru_pkg::KEY_W-1:0]    key;
   logic [PAYLOAD_WIDTH-1:0]       payload_in;

   modport source (output valid, operation, key, payload_in, input ready);
   modport sink   (input valid, operation, key, payload_in, output ready);
endinterface

### hdl/aclru_rsp_if.sv
// Response channel: hit flag, payload, slot and counters with valid/ready handshake.
interface aclru_rsp_if #(
   parameter int PAYLOAD_WIDTH = aclru_pkg::PAYLOAD_WIDTH_DEFAULT
);
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [PAYLOAD_WIDTH-1:0]       payload_out;
   logic [aclru_pkg::SLOT_W-1:0]   slot_used;
   logic [aclru_pkg::COUNT_W-1:0]  hit_total;
   logic [aclru_pkg::COUNT_W-1:0]  miss_total;

   modport source (output valid, hit, payload_out, slot_used, hit_total, miss_total,
                   input ready);
   modport sink   (input valid, hit, payload_out, slot_used, hit_total, miss_total,
                   output ready);
endinterface

### hdl/aclru_cell.sv
// One cache entry with its stage of the search chain.
module aclru_cell #(
   parameter int  INDEX,
   parameter int  IDX_W,
   parameter int  PAYLOAD_WIDTH,
   parameter type sweep_type,
   parameter type wcmd_type
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [aclru_pkg::KEY_W-1:0] probe_key,
   input  sweep_type                   up_sweep,
   output sweep_type                   down_sweep,
   input  wcmd_type                    wcmd
);
   import aclru_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic                      valid_ff, valid_in;
   logic [KEY_W-1:0]          key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0]  payload_ff, payload_in;
   logic [STAMP_W-1:0]        stamp_ff, stamp_in;
   sweep_type                 sweep_ff, sweep_in;
   logic                      selected;

   // Fold this entry into the search result arriving from the previous cell.
   always_comb begin
      sweep_in        = sweep_ff;
      sweep_in.active = up_sweep.active;
      if (up_sweep.active) begin
         sweep_in        = up_sweep;
         if (valid_ff && (key_ff == probe_key) && !up_sweep.match) begin
            sweep_in.match         = 1'b1;
            sweep_in.match_idx     = MY_IDX;
            sweep_in.match_payload = payload_ff;
         end
         if (!valid_ff && !up_sweep.inv) begin
            sweep_in.inv     = 1'b1;
            sweep_in.inv_idx = MY_IDX;
         end
         if (valid_ff && (!up_sweep.min_found || (stamp_ff < up_sweep.oldest_stamp))) begin
            sweep_in.min_found    = 1'b1;
            sweep_in.oldest_stamp = stamp_ff;
            sweep_in.min_idx      = MY_IDX;
         end
      end
   end

   // Apply the commit command when it addresses this entry.
   assign selected = wcmd.en && (wcmd.idx == MY_IDX);

   always_comb begin
      valid_in   = valid_ff;
      key_in     = key_ff;
      payload_in = payload_ff;
      stamp_in   = stamp_ff;
      if (selected) begin
         if (wcmd.set_entry) begin
            key_in     = wcmd.key;
            payload_in = wcmd.payload;
         end
         if (wcmd.set_stamp) begin
            stamp_in = wcmd.stamp;
         end
         if (wcmd.set_valid) begin
            valid_in = 1'b1;
         end
         if (wcmd.clr_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   // Entry storage; only the valid bit and the chain token are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         sweep_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sweep_ff <= sweep_in;
      end
      key_ff     <= key_in;
      payload_ff <= payload_in;
      stamp_ff   <= stamp_in;
   end

   assign down_sweep = sweep_ff;

endmodule

### hdl/assoc_cache_lru_replace.sv
// Top level of the fully associative cache with LRU replacement.
//
//   channel  direction  handshake       payload
//   req_chan in         valid/ready     operation, key, payload_in
//   rsp_chan out        valid/ready     hit, payload_out, slot_used, hit_total, miss_total
//
// After its transfer a request launches the search token, which is registered in each cell along
// the chain; a commit state then writes the entry and loads the response, and the next request
// is taken only in the idle state after the commit, so requests do not overlap.
// Reset clears the valid bits, the use clock, the counters and the controller.
// A pending response does not stop the idle state taking a request, but the commit waits while
// the response register still holds an unaccepted transfer, and the input is blocked meanwhile.
module assoc_cache_lru_replace #(
   parameter int ENTRIES       = aclru_pkg::ENTRIES_DEFAULT,
   parameter int PAYLOAD_WIDTH = aclru_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   aclru_req_if.sink   req_chan,
   aclru_rsp_if.source rsp_chan
);
   import aclru_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   typedef struct packed {
      logic                     active;
      logic                     match;
      logic [IDX_W-1:0]         match_idx;
      logic [PAYLOAD_WIDTH-1:0] match_payload;
      logic                     inv;
      logic [IDX_W-1:0]         inv_idx;
      logic                     min_found;
      logic [STAMP_W-1:0]       oldest_stamp;
      logic [IDX_W-1:0]         min_idx;
   } sweep_type;

   typedef struct packed {
      logic                     en;
      logic [IDX_W-1:0]         idx;
      logic                     set_entry;
      logic                     set_stamp;
      logic                     set_valid;
      logic                     clr_valid;
      logic [KEY_W-1:0]         key;
      logic [PAYLOAD_WIDTH-1:0] payload;
      logic [STAMP_W-1:0]       stamp;
   } wcmd_type;

   state_type                 state_ff, state_in;
   logic                      launch_ff;
   logic [OP_W-1:0]           op_ff;
   logic [KEY_W-1:0]          key_ff;
   logic [PAYLOAD_WIDTH-1:0]  payload_ff;
   logic [STAMP_W-1:0]        use_clock_ff, use_clock_in;
   logic [COUNT_W-1:0]        hit_cnt_ff, hit_cnt_in;
   logic [COUNT_W-1:0]        miss_cnt_ff, miss_cnt_in;

   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff;
   logic [PAYLOAD_WIDTH-1:0]  rsp_payload_ff;
   logic [SLOT_W-1:0]         rsp_slot_ff;
   logic [COUNT_W-1:0]        rsp_hit_total_ff;
   logic [COUNT_W-1:0]        rsp_miss_total_ff;

   logic                      req_fire;
   logic                      rsp_free;
   logic                      commit_fire;
   sweep_type                 head_sweep;
   sweep_type                 link [ENTRIES];
   sweep_type                 found;
   logic [ENTRIES:0]          token_vec;
   wcmd_type                  wcmd;
   logic [IDX_W-1:0]          victim_idx;
   logic [IDX_W-1:0]          slot_idx;
   logic [IDX_W+SLOT_W-1:0]   slot_wide;
   logic                      res_hit;
   logic [PAYLOAD_WIDTH-1:0]  res_payload;
   logic                      bump_clock;
   logic                      count_hit;
   logic                      count_miss;

   // Handshake conditions.
   assign req_fire    = req_chan.valid && req_chan.ready;
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   assign commit_fire = (state_ff == ST_COMMIT) && rsp_free;

   // Next state of the controller.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (link[ENTRIES-1].active) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_chan.ready = 1'b0;
      case (state_ff)
         ST_IDLE:   req_chan.ready = 1'b1;
         ST_SWEEP:  req_chan.ready = 1'b0;
         ST_COMMIT: req_chan.ready = 1'b0;
         default:   req_chan.ready = 1'b0;
      endcase
   end

   // The search token enters the first cell with an empty result.
   always_comb begin
      head_sweep        = '0;
      head_sweep.active = launch_ff;
   end

   // Chain of entry cells; each hands its partial search result onward.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      sweep_type up_sweep;
      if (i == 0) begin : g_head
         assign up_sweep = head_sweep;
      end else begin : g_body
         assign up_sweep = link[i-1];
      end
      aclru_cell #(
         .INDEX         (i),
         .IDX_W         (IDX_W),
         .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
         .sweep_type    (sweep_type),
         .wcmd_type     (wcmd_type)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .probe_key  (key_ff),
         .up_sweep   (up_sweep),
         .down_sweep (link[i]),
         .wcmd       (wcmd)
      );
      assign token_vec[i+1] = link[i].active;
   end
   assign token_vec[0] = head_sweep.active;

   // The last cell holds the complete search result until the next token.
   assign found = link[ENTRIES-1];

   always_comb begin
      if (found.match) begin
         victim_idx = found.match_idx;
      end else if (found.inv) begin
         victim_idx = found.inv_idx;
      end else begin
         victim_idx = found.min_idx;
      end
   end

   // Commit decision: entry write, result fields and counter updates.
   always_comb begin
      wcmd         = '0;
      wcmd.key     = key_ff;
      wcmd.payload = payload_ff;
      wcmd.stamp   = use_clock_ff + STAMP_W'(1);
      res_hit      = 1'b0;
      res_payload  = '0;
      slot_idx     = '0;
      bump_clock   = 1'b0;
      count_hit    = 1'b0;
      count_miss   = 1'b0;
      case (op_ff)
         OP_LOOKUP: begin
            if (found.match) begin
               wcmd.en        = 1'b1;
               wcmd.idx       = found.match_idx;
               wcmd.set_stamp = 1'b1;
               res_hit        = 1'b1;
               res_payload    = found.match_payload;
               slot_idx       = found.match_idx;
               bump_clock     = 1'b1;
               count_hit      = 1'b1;
            end else begin
               count_miss = 1'b1;
            end
         end
         OP_INSERT: begin
            wcmd.en        = 1'b1;
            wcmd.idx       = victim_idx;
            wcmd.set_entry = 1'b1;
            wcmd.set_stamp = 1'b1;
            wcmd.set_valid = 1'b1;
            res_hit        = found.match;
            slot_idx       = victim_idx;
            bump_clock     = 1'b1;
         end
         OP_INVALIDATE: begin
            if (found.match) begin
               wcmd.en        = 1'b1;
               wcmd.idx       = found.match_idx;
               wcmd.clr_valid = 1'b1;
               res_hit        = 1'b1;
               slot_idx       = found.match_idx;
            end
         end
         default: begin
            res_hit = 1'b0;
         end
      endcase
      wcmd.en = wcmd.en && commit_fire;
   end

   // The reported slot keeps the low four bits of the entry index.
   assign slot_wide = {{SLOT_W{1'b0}}, slot_idx};

   // Use clock and saturating counters.
   always_comb begin
      use_clock_in = use_clock_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      if (commit_fire) begin
         if (bump_clock) begin
            use_clock_in = use_clock_ff + STAMP_W'(1);
         end
         if (count_hit && (hit_cnt_ff != COUNT_MAX)) begin
            hit_cnt_in = hit_cnt_ff + COUNT_W'(1);
         end
         if (count_miss && (miss_cnt_ff != COUNT_MAX)) begin
            miss_cnt_in = miss_cnt_ff + COUNT_W'(1);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         use_clock_ff <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= req_fire;
         use_clock_ff <= use_clock_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         if (commit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture on each accepted transfer.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff      <= req_chan.operation;
         key_ff     <= req_chan.key;
         payload_ff <= req_chan.payload_in;
      end
   end

   // Response register, loaded at commit.
   always_ff @(posedge clock) begin
      if (commit_fire) begin
         rsp_hit_ff        <= res_hit;
         rsp_payload_ff    <= res_payload;
         rsp_slot_ff       <= slot_wide[SLOT_W-1:0];
         rsp_hit_total_ff  <= hit_cnt_in;
         rsp_miss_total_ff <= miss_cnt_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.payload_out = rsp_payload_ff;
   assign rsp_chan.slot_used   = rsp_slot_ff;
   assign rsp_chan.hit_total   = rsp_hit_total_ff;
   assign rsp_chan.miss_total  = rsp_miss_total_ff;

   // Only one search token is ever in flight along the chain.
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_vec))
      else $error("more than one search token in the chain");

   // The token leaves the last cell only while the controller is sweeping.
   a_token_in_sweep: assert property (@(posedge clock) disable iff (reset)
      link[ENTRIES-1].active |-> (state_ff == ST_SWEEP))
      else $error("search result arrived outside the sweep state");

   // Counters move only on a committed lookup.
   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      (!(commit_fire && (op_ff == OP_LOOKUP))) |=>
         ($stable(hit_cnt_ff) && $stable(miss_cnt_ff)))
      else $error("counter changed without a lookup commit");

   // A committed lookup never moves both counters.
   a_one_counter: assert property (@(posedge clock) disable iff (reset)
      (commit_fire && (op_ff == OP_LOOKUP)) |=>
         ($stable(hit_cnt_ff) || $stable(miss_cnt_ff)))
      else $error("lookup moved both counters");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the fully associative LRU cache, with directed and random traffic.
module testbench;
   import aclru_pkg::*;

   localparam int NUM_ENTRIES   = 16;
   localparam int DATA_W        = 64;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;
   localparam int POOL_SIZE     = 24;
   localparam int SETTLE_CYCLES = NUM_ENTRIES + 6;

   // One reply as the cache should present it.
   typedef struct {
      logic                 hit;
      logic [DATA_W-1:0]    payload_out;
      logic [SLOT_W-1:0]    slot_used;
      logic [COUNT_W-1:0]   hit_total;
      logic [COUNT_W-1:0]   miss_total;
   } cache_reply_type;

   logic clock;
   logic reset;

   aclru_req_if #(.PAYLOAD_WIDTH(DATA_W)) req_chan ();
   aclru_rsp_if #(.PAYLOAD_WIDTH(DATA_W)) rsp_chan ();

   assoc_cache_lru_replace #(
      .ENTRIES       (NUM_ENTRIES),
      .PAYLOAD_WIDTH (DATA_W)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the cache contents and counters.
   logic                 shadow_valid   [NUM_ENTRIES] = '{default: 1'b0};
   logic [KEY_W-1:0]     shadow_key     [NUM_ENTRIES];
   logic [DATA_W-1:0]    shadow_payload [NUM_ENTRIES];
   logic [STAMP_W-1:0]   shadow_stamp   [NUM_ENTRIES];
   logic [STAMP_W-1:0]   use_clock  = '0;
   logic [COUNT_W-1:0]   hit_count  = '0;
   logic [COUNT_W-1:0]   miss_count = '0;

   cache_reply_type      expected_replies [$];
   cache_reply_type      oldest_reply;
   logic [KEY_W-1:0]     key_pool [POOL_SIZE];

   int error_count    = 0;
   int requests_seen  = 0;
   int replies_seen   = 0;
   int eviction_count = 0;
   int quiet_cycles   = 0;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int hold_served    = 0;
   int hold_left      = 0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Prints one line per failure and keeps the tally.
   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("reply %0d field %s: got %h, expected %h",
                                   replies_seen, name, got, want));
   endtask

   // Works out the reply to one request and advances the shadow state.
   function automatic cache_reply_type predict_reply(input logic [OP_W-1:0] op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [DATA_W-1:0] data);
      cache_reply_type r;
      int found;
      int target;
      int i;
      r.hit = 1'b0;
      r.payload_out = '0;
      r.slot_used = '0;
      found = -1;
      for (i = NUM_ENTRIES - 1; i >= 0; i--)
         if (shadow_valid[i] && shadow_key[i] == key)
            found = i;
      case (op)
         OP_LOOKUP: begin
            if (found >= 0) begin
               use_clock = use_clock + STAMP_W'(1);
               shadow_stamp[found] = use_clock;
               r.hit = 1'b1;
               r.payload_out = shadow_payload[found];
               r.slot_used = SLOT_W'(found);
               if (hit_count != COUNT_MAX)
                  hit_count = hit_count + COUNT_W'(1);
            end else if (miss_count != COUNT_MAX) begin
               miss_count = miss_count + COUNT_W'(1);
            end
         end
         OP_INSERT: begin
            target = found;
            if (found >= 0) begin
               r.hit = 1'b1;
            end else begin
               // First free slot, else the oldest stamp with the lowest index on a tie.
               for (i = NUM_ENTRIES - 1; i >= 0; i--)
                  if (!shadow_valid[i])
                     target = i;
               if (target < 0) begin
                  target = 0;
                  for (i = 1; i < NUM_ENTRIES; i++)
                     if (shadow_stamp[i] < shadow_stamp[target])
                        target = i;
                  eviction_count++;
               end
            end
            use_clock = use_clock + STAMP_W'(1);
            shadow_key[target] = key;
            shadow_payload[target] = data;
            shadow_stamp[target] = use_clock;
            shadow_valid[target] = 1'b1;
            r.slot_used = SLOT_W'(target);
         end
         OP_INVALIDATE: begin
            if (found >= 0) begin
               shadow_valid[found] = 1'b0;
               r.hit = 1'b1;
               r.slot_used = SLOT_W'(found);
            end
         end
         default: ;
      endcase
      r.hit_total = hit_count;
      r.miss_total = miss_count;
      return r;
   endfunction

   // Offers one request, idling beforehand at the current rate, and returns once it transfers.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.operation  <= op;
      req_chan.key        <= key;
      req_chan.payload_in <= data;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         rsp_chan.ready <= 1'b0;
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Predicts on every request transfer, checks every reply transfer and guards against hangs.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            expected_replies.push_back(predict_reply(req_chan.operation, req_chan.key,
                                                     req_chan.payload_in));
            requests_seen++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("reply %0d arrived with no request outstanding",
                                         replies_seen));
            end else begin
               oldest_reply = expected_replies.pop_front();
               check_field("hit", 64'(rsp_chan.hit), 64'(oldest_reply.hit));
               check_field("payload_out", 64'(rsp_chan.payload_out),
                           64'(oldest_reply.payload_out));
               check_field("slot_used", 64'(rsp_chan.slot_used),
                           64'(oldest_reply.slot_used));
               check_field("hit_total", 64'(rsp_chan.hit_total),
                           64'(oldest_reply.hit_total));
               check_field("miss_total", 64'(rsp_chan.miss_total),
                           64'(oldest_reply.miss_total));
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("FAIL assoc_cache_lru_replace");
            $finish;
         end
      end
   end

   // Lookup miss on an empty cache, first fills at the key extremes and an update in place.
   task automatic test_empty_and_update;
      send_request(OP_LOOKUP, '0, '0);
      send_request(OP_INSERT, '0, '1);
      send_request(OP_INSERT, '1, '0);
      send_request(OP_LOOKUP, '0, 64'h0123_4567_89AB_CDEF);
      send_request(OP_INSERT, '0, 64'h5555_5555_AAAA_AAAA);
   endtask

   // Invalidate with and without a match, a lookup of the cleared key and the spare op code.
   task automatic test_invalidate_and_unused;
      send_request(OP_INVALIDATE, '1, '1);
      send_request(OP_INVALIDATE, '1, '0);
      send_request(OP_LOOKUP, '1, '0);
      send_request(OP_UNUSED, '0, '1);
   endtask

   // Fills every slot, then forces a least-recently-used eviction of the oldest key.
   task automatic test_fill_and_evict;
      int i;
      for (i = 1; i < NUM_ENTRIES; i++)
         send_request(OP_INSERT, 64'h8000_0000_0000_0000 | KEY_W'(i), {$urandom, $urandom});
      send_request(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, {$urandom, $urandom});
      send_request(OP_LOOKUP, '0, '0);
   endtask

   // The receiver holds off while requests keep coming, so the cache backs up to its input.
   task automatic test_receiver_hold;
      int i;
      hold_requests <= hold_requests + 1;
      for (i = 0; i < 8; i++)
         send_request((i % 2 == 0) ? OP_INSERT : OP_LOOKUP,
                      key_pool[$urandom_range(POOL_SIZE - 1)], {$urandom, $urandom});
   endtask

   // Random mix over a small key pool, so hits, updates and evictions are frequent.
   task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
      int sent;
      int i;
      int pick;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
      for (i = 0; i < POOL_SIZE; i++)
         key_pool[i] = {$urandom, $urandom};
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 45)
            op = OP_LOOKUP;
         else if (pick < 80)
            op = OP_INSERT;
         else if (pick < 95)
            op = OP_INVALIDATE;
         else
            op = OP_UNUSED;
         pick = $urandom_range(99);
         key = key_pool[$urandom_range(POOL_SIZE - 1)];
         // Near misses differ from a live key in one bit; a few keys are fresh.
         if (pick >= 90)
            key = {$urandom, $urandom};
         else if (pick >= 80)
            key = key ^ (64'd1 << $urandom_range(KEY_W - 1));
         send_request(op, key, {$urandom, $urandom});
         if (op != OP_UNUSED)
            sent++;
      end
   endtask

   // Test sequence.
   initial begin
      int i;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_LOOKUP;
      req_chan.key = '0;
      req_chan.payload_in = '0;
      for (i = 0; i < POOL_SIZE; i++)
         key_pool[i] = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_update();
      test_invalidate_and_unused();
      test_fill_and_evict();
      test_random_traffic(270, 27, 73);
      test_receiver_hold();
      test_random_traffic(270, 73, 27);
      test_random_traffic(260, 0, 0);

      // Let every outstanding reply drain, then allow time for any stray transfer.
      req_chan.valid <= 1'b0;
      while (expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0)
         report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));

      $display("Ran %0d requests and checked %0d replies: %0d lookup hits, %0d misses.",
               requests_seen, replies_seen, hit_count, miss_count);
      $display("Saw %0d evictions over both idling mixes, no idling and a %0d-cycle hold-off.",
               eviction_count, HOLD_CYCLES);
      if (error_count == 0)
         $display("PASS assoc_cache_lru_replace");
      else
         $display("FAIL assoc_cache_lru_replace");
      $finish;
   end

endmodule
